@@ hdl/rau_pkg.sv @@
// shared types, constants and widths of the rational arithmetic unit
`timescale 1ns / 1ps

package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int FIELD_W       = 16;
	localparam int FX_W          = (OPERAND_WIDTH > FIELD_W) ? OPERAND_WIDTH : FIELD_W;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int NUM_W         = PROD_W + 1;
	localparam int MAG_W         = PROD_W;
	localparam int CNT_W         = $clog2(MAG_W);
	localparam int K_W           = $clog2(MAG_W + 1);
	localparam int EXT_W         = (MAG_W + 1 > 33) ? MAG_W + 1 : 33;

	localparam int RES_NUM_W  = 32;
	localparam int RES_DEN_W  = 30;
	localparam int CMP_W      = 2;
	localparam int CMD_W      = 3;
	localparam int S_TDATA_W  = 4 * FIELD_W;
	localparam int M_TDATA_W  = 64;

	localparam longint RES_NUM_MAX = 64'sd2147483647;
	localparam longint RES_NUM_MIN = -64'sd2147483648;
	localparam longint RES_DEN_MAX = 64'sd1073741823;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_CMP = 3'd4
	} cmd_t;

	typedef enum logic [CMP_W-1:0] {
		CMP_LESS    = 2'd0,
		CMP_EQUAL   = 2'd1,
		CMP_GREATER = 2'd2
	} cmp_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_MUL1,
		T_MUL2,
		T_MUL3,
		T_SETUP,
		T_WAIT,
		T_DONE
	} top_state_t;

	typedef enum logic [1:0] {
		R_IDLE,
		R_GCD,
		R_DIV,
		R_DONE
	} red_state_t;

	typedef struct packed {
		logic                        done;
		logic signed [RES_NUM_W-1:0] num;
		logic [RES_DEN_W-1:0]        den;
	} red_res_t;

endpackage

@@ hdl/rau_reduce.sv @@
// fraction reduction: binary gcd followed by a two-lane restoring divider
`timescale 1ns / 1ps

module rau_reduce
	import rau_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [PROD_W-1:0] den,
	output red_res_t                res
);

	localparam logic signed [EXT_W-1:0] NMAX_X = EXT_W'(RES_NUM_MAX);
	localparam logic signed [EXT_W-1:0] NMIN_X = EXT_W'(RES_NUM_MIN);
	localparam logic signed [EXT_W-1:0] DMAX_X = EXT_W'(RES_DEN_MAX);

	red_state_t state_q, state_d;

	logic [MAG_W-1:0] u_q, v_q, g_q, qn_q, qd_q, rn_q, rd_q;
	logic [K_W-1:0]   k_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;

	logic signed [NUM_W-1:0]  num_abs;
	logic signed [PROD_W-1:0] den_abs;
	logic                     gcd_eq, cnt_end;
	logic [MAG_W:0]           rn_sh, rd_sh, rn_sub, rd_sub;
	logic signed [EXT_W-1:0]  qn_x, sn_x, sn_sat, qd_x, qd_sat;

	assign num_abs = num[NUM_W-1] ? -num : num;
	assign den_abs = den[PROD_W-1] ? -den : den;
	assign gcd_eq  = (u_q == v_q);
	assign cnt_end = (cnt_q == CNT_W'(MAG_W - 1));

	assign rn_sh  = {rn_q, qn_q[MAG_W-1]};
	assign rd_sh  = {rd_q, qd_q[MAG_W-1]};
	assign rn_sub = rn_sh - {1'b0, g_q};
	assign rd_sub = rd_sh - {1'b0, g_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			R_IDLE: begin
				if (start) begin
					state_d = (num == '0) ? R_DONE : R_GCD;
				end
			end
			R_GCD: begin
				if (gcd_eq) begin
					state_d = R_DIV;
				end
			end
			R_DIV: begin
				if (cnt_end) begin
					state_d = R_DONE;
				end
			end
			R_DONE: state_d = R_IDLE;
			default: state_d = R_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				if (start) begin
					if (num == '0) begin
						qn_q  <= '0;
						qd_q  <= MAG_W'(1);
						neg_q <= 1'b0;
					end else begin
						neg_q <= num[NUM_W-1] ^ den[PROD_W-1];
						u_q   <= num_abs[MAG_W-1:0];
						v_q   <= MAG_W'(den_abs);
						qn_q  <= num_abs[MAG_W-1:0];
						qd_q  <= MAG_W'(den_abs);
						k_q   <= '0;
					end
				end
			end
			R_GCD: begin
				if (gcd_eq) begin
					g_q   <= u_q << k_q;
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= '0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + K_W'(1);
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q > v_q) begin
					u_q <= (u_q - v_q) >> 1;
				end else begin
					v_q <= (v_q - u_q) >> 1;
				end
			end
			R_DIV: begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (!rn_sub[MAG_W]) begin
					rn_q <= rn_sub[MAG_W-1:0];
					qn_q <= {qn_q[MAG_W-2:0], 1'b1};
				end else begin
					rn_q <= rn_sh[MAG_W-1:0];
					qn_q <= {qn_q[MAG_W-2:0], 1'b0};
				end
				if (!rd_sub[MAG_W]) begin
					rd_q <= rd_sub[MAG_W-1:0];
					qd_q <= {qd_q[MAG_W-2:0], 1'b1};
				end else begin
					rd_q <= rd_sh[MAG_W-1:0];
					qd_q <= {qd_q[MAG_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// sign and saturation of the reduced pair
	always_comb begin
		qn_x = EXT_W'(qn_q);
		qd_x = EXT_W'(qd_q);
		sn_x = neg_q ? -qn_x : qn_x;
		if (sn_x > NMAX_X) begin
			sn_sat = NMAX_X;
		end else if (sn_x < NMIN_X) begin
			sn_sat = NMIN_X;
		end else begin
			sn_sat = sn_x;
		end
		qd_sat = (qd_x > DMAX_X) ? DMAX_X : qd_x;
	end

	assign res.done = (state_q == R_DONE);
	assign res.num  = sn_sat[RES_NUM_W-1:0];
	assign res.den  = qd_sat[RES_DEN_W-1:0];

endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// states: T_MUL1, T_MUL2, T_MUL3, T_SETUP, T_DONE; unless reduction is skipped, T_WAIT comes
// before T_DONE and spans the binary gcd loop and 32-step divider; a zero numerator skips both
// throughput: one item at a time; compare, unused codes and division by zero skip reduction
// the three cross products share one multiplier in states T_MUL1, T_MUL2 and T_MUL3
// a finished result waits in the output register while the next item is taken
// reset: arst_n asynchronous, clears the sequencer and the output valid
`timescale 1ns / 1ps

module rational_arithmetic_unit
	import rau_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // a_num, a_den, b_num, b_den
	input  logic [CMD_W-1:0]     s_tuser,   // command
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // res_num, res_den, cmp_result
	output logic                 m_tuser    // div_zero
);

	top_state_t state_q, state_d;

	logic signed [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic [CMD_W-1:0]                cmd_q;
	logic signed [PROD_W-1:0]        x_q, y_q, d_q;

	logic signed [RES_NUM_W-1:0] rn_q, out_num_q;
	logic [RES_DEN_W-1:0]        rd_q, out_den_q;
	logic                        dz_q, out_dz_q;
	logic [CMP_W-1:0]            cmp_q, out_cmp_q;
	logic                        m_tvalid_q;

	logic                            s_xfer, m_xfer, out_free, red_start, skip_red;
	logic signed [OPERAND_WIDTH-1:0] ma, mb;
	logic signed [PROD_W-1:0]        prod;
	logic signed [NUM_W-1:0]         x_x, y_x, num_c, diff_c;
	logic [CMP_W-1:0]                cmp_c;
	red_res_t                        red_res;

	// operand extraction; a zero denominator becomes one
	function automatic logic signed [OPERAND_WIDTH-1:0] get_op(input logic [FIELD_W-1:0] f,
			input logic one_if_zero);
		logic [FX_W-1:0]                 fx;
		logic signed [OPERAND_WIDTH-1:0] op;
		fx = FX_W'(f);
		op = fx[OPERAND_WIDTH-1:0];
		if (one_if_zero && op == '0) begin
			op = OPERAND_WIDTH'(1);
		end
		return op;
	endfunction

	assign s_xfer   = s_tvalid && s_tready;
	assign m_xfer   = m_tvalid_q && m_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// shared multiplier
	always_comb begin
		ma = an_q;
		mb = bd_q;
		case (state_q)
			T_MUL1: begin
				ma = an_q;
				mb = (cmd_q == CMD_MUL) ? bn_q : bd_q;
			end
			T_MUL2: begin
				ma = bn_q;
				mb = ad_q;
			end
			T_MUL3: begin
				ma = ad_q;
				mb = (cmd_q == CMD_DIV) ? bn_q : bd_q;
			end
			default: begin
			end
		endcase
	end

	assign prod = ma * mb;

	assign x_x    = {x_q[PROD_W-1], x_q};
	assign y_x    = {y_q[PROD_W-1], y_q};
	assign diff_c = x_x - y_x;

	always_comb begin
		case (cmd_q)
			CMD_ADD: num_c = x_x + y_x;
			CMD_SUB: num_c = diff_c;
			default: num_c = x_x;
		endcase
	end

	// sign of the cross difference flips when exactly one denominator is negative
	always_comb begin
		if (diff_c == '0) begin
			cmp_c = CMP_EQUAL;
		end else if (diff_c[NUM_W-1] ^ ad_q[OPERAND_WIDTH-1] ^ bd_q[OPERAND_WIDTH-1]) begin
			cmp_c = CMP_LESS;
		end else begin
			cmp_c = CMP_GREATER;
		end
	end

	assign skip_red  = (cmd_q > CMD_DIV) || (cmd_q == CMD_DIV && bn_q == '0);
	assign red_start = (state_q == T_SETUP) && !skip_red;

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE:  state_d = s_xfer ? T_MUL1 : T_IDLE;
			T_MUL1:  state_d = T_MUL2;
			T_MUL2:  state_d = T_MUL3;
			T_MUL3:  state_d = T_SETUP;
			T_SETUP: state_d = skip_red ? T_DONE : T_WAIT;
			T_WAIT:  state_d = red_res.done ? T_DONE : T_WAIT;
			T_DONE:  state_d = out_free ? T_IDLE : T_DONE;
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == T_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == T_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_xfer) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			an_q  <= get_op(s_tdata[FIELD_W-1:0], 1'b0);
			ad_q  <= get_op(s_tdata[2*FIELD_W-1:FIELD_W], 1'b1);
			bn_q  <= get_op(s_tdata[3*FIELD_W-1:2*FIELD_W], 1'b0);
			bd_q  <= get_op(s_tdata[4*FIELD_W-1:3*FIELD_W], 1'b1);
			cmd_q <= s_tuser;
		end
		case (state_q)
			T_MUL1: x_q <= prod;
			T_MUL2: y_q <= prod;
			T_MUL3: d_q <= prod;
			T_SETUP: begin
				rd_q <= RES_DEN_W'(1);
				if (cmd_q == CMD_CMP) begin
					rn_q  <= '0;
					dz_q  <= 1'b0;
					cmp_q <= cmp_c;
				end else if (cmd_q == CMD_DIV && bn_q == '0) begin
					rn_q  <= RES_NUM_W'(1);
					dz_q  <= 1'b1;
					cmp_q <= CMP_LESS;
				end else begin
					rn_q  <= '0;
					dz_q  <= 1'b0;
					cmp_q <= CMP_LESS;
				end
			end
			T_WAIT: begin
				if (red_res.done) begin
					rn_q <= red_res.num;
					rd_q <= red_res.den;
				end
			end
			default: begin
			end
		endcase
		if (state_q == T_DONE && out_free) begin
			out_num_q <= rn_q;
			out_den_q <= rd_q;
			out_dz_q  <= dz_q;
			out_cmp_q <= cmp_q;
		end
	end

	rau_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.num    (num_c),
		.den    (d_q),
		.res    (red_res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_cmp_q, out_den_q, out_num_q};
	assign m_tuser  = out_dz_q;

endmodule

@@ hdl/rau_checker.sv @@
// port-level checks of the rational arithmetic unit and their bind
`timescale 1ns / 1ps

module rau_checker
	import rau_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic [CMD_W-1:0]     s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	logic [RES_NUM_W-1:0] r_num;
	logic [RES_DEN_W-1:0] r_den;
	logic [CMP_W-1:0]     r_cmp;

	assign r_num = m_tdata[RES_NUM_W-1:0];
	assign r_den = m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W];
	assign r_cmp = m_tdata[RES_NUM_W+RES_DEN_W+CMP_W-1:RES_NUM_W+RES_DEN_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> r_den != '0)
		else $error("zero result denominator");

	a_div_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> r_num == RES_NUM_W'(1) && r_den == RES_DEN_W'(1)
			&& r_cmp == CMP_LESS)
		else $error("division by zero without a 1/1 result");

	a_cmp_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> r_cmp == CMP_LESS || r_cmp == CMP_EQUAL || r_cmp == CMP_GREATER)
		else $error("bad compare code");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
